// ----- sv/lzrle_pkg.sv -----
// Shared types and constants for the LZ/RLE byte decompressor.
package lzrle_pkg;

  localparam int HIST_DEPTH = 1024;
  localparam int HIST_AW = 10;
  localparam int RUN_W = 15;

  localparam logic [3:0] PH_CTRL     = 4'd0;
  localparam logic [3:0] PH_LIT_EXT  = 4'd1;
  localparam logic [3:0] PH_FILL_EXT = 4'd2;
  localparam logic [3:0] PH_FILL_VAL = 4'd3;
  localparam logic [3:0] PH_REF_LOW  = 4'd4;
  localparam logic [3:0] PH_PAT_CNT  = 4'd5;
  localparam logic [3:0] PH_LIT_COPY = 4'd6;
  localparam logic [3:0] PH_PAT_LIT  = 4'd7;
  localparam logic [3:0] PH_FILL_OUT = 4'd8;
  localparam logic [3:0] PH_REF_OUT  = 4'd9;
  localparam logic [3:0] PH_PAT_REP  = 4'd10;

  localparam logic CFG_INPUT_SIZE  = 1'b0;
  localparam logic CFG_OUTPUT_SIZE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] src_byte;
  } in_item_t;

  typedef struct packed {
    logic       byte_taken;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       finished;
  } out_item_t;

  // Decoded step handed from the token decoder to the emit stage.
  typedef struct packed {
    logic               taken;
    logic               emit;
    logic               lookup;
    logic [7:0]         lit_byte;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_AW-1:0] rd_addr;
    logic               finished;
  } step_t;

endpackage

// ----- sv/lz_rle_byte_decompressor.sv -----
// An input is decoded into the emit stage with its history read; the result register follows.
// Throughput: one item per cycle unless results stall; the history RAM takes one read and one
// write each cycle. A stalled result holds one item in the emit stage; a second stalled item
// stops input. Reset is synchronous; afterwards the 1024-byte history is cleared, during which
// in_ready stays low. Configuration writes are taken at any time.
module lz_rle_byte_decompressor #(
  parameter int SIZE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lzrle_pkg::in_item_t   in_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output lzrle_pkg::out_item_t  res_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SIZE_BITS-1:0]  cfg_data
);

  logic [SIZE_BITS-1:0] input_size;
  logic [SIZE_BITS-1:0] output_size;
  logic                 accept;
  lzrle_pkg::step_t     step;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_size  <= '0;
      output_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lzrle_pkg::CFG_INPUT_SIZE:  input_size  <= cfg_data;
        lzrle_pkg::CFG_OUTPUT_SIZE: output_size <= cfg_data;
        default: ;
      endcase
    end
  end

  lzrle_decode #(
    .SIZE_BITS (SIZE_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_data),
    .input_size  (input_size),
    .output_size (output_size),
    .step        (step)
  );

  lzrle_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .step       (step),
    .can_accept (in_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule

// ----- sv/lzrle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/lzrle_decode.sv -----
// Token decoder: holds the parse state and works out one step per accepted item.
module lzrle_decode #(
  parameter int SIZE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  lzrle_pkg::in_item_t    item,
  input  logic [SIZE_BITS-1:0]   input_size,
  input  logic [SIZE_BITS-1:0]   output_size,
  output lzrle_pkg::step_t       step
);

  localparam int RW = lzrle_pkg::RUN_W;
  localparam int AW = lzrle_pkg::HIST_AW;

  logic [SIZE_BITS-1:0] written_count, written_count_next;
  logic [SIZE_BITS-1:0] read_count, read_count_next;
  logic [3:0]           phase, phase_next;
  logic [RW-1:0]        copy_left, copy_left_next;
  logic [RW-1:0]        repeat_left, repeat_left_next;
  logic [AW-1:0]        distance, distance_next;
  logic [7:0]           fill_value, fill_value_next;

  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] rem_m1;
  logic                 out_done;
  logic [7:0]           b;
  logic                 cmd;
  logic [RW-1:0]        ext;
  logic [RW-1:0]        cl;
  logic [RW-1:0]        cd;

  function automatic logic [RW-1:0] clamp_run(input logic [RW-1:0] n,
                                              input logic [SIZE_BITS-1:0] r);
    if ({{(SIZE_BITS-RW){1'b0}}, n} < r) begin
      return n;
    end
    return r[RW-1:0];
  endfunction

  function automatic logic [RW-1:0] dec_sat(input logic [RW-1:0] n);
    if (n != '0) begin
      return n - RW'(1);
    end
    return n;
  endfunction

  assign cmd      = item.command;
  assign b        = item.src_byte;
  assign rem      = (output_size > written_count) ? output_size - written_count : '0;
  assign rem_m1   = rem - SIZE_BITS'(1);
  assign out_done = (written_count >= output_size);
  assign ext      = {2'b00, b, 5'b00000};

  always_comb begin
    written_count_next = written_count;
    read_count_next    = read_count;
    phase_next         = phase;
    copy_left_next     = copy_left;
    repeat_left_next   = repeat_left;
    distance_next      = distance;
    fill_value_next    = fill_value;
    step               = '0;
    cl                 = '0;
    cd                 = '0;
    step.wr_addr       = written_count[AW-1:0];
    step.rd_addr       = written_count[AW-1:0] - distance - AW'(1);

    if (phase != lzrle_pkg::PH_CTRL && out_done) begin
      // Output size was lowered inside a token: drop the token.
      phase_next = lzrle_pkg::PH_CTRL;
    end else begin
      case (phase)
        lzrle_pkg::PH_LIT_EXT: begin
          if (cmd) begin
            step.taken     = 1'b1;
            cl             = clamp_run(copy_left + ext, rem);
            copy_left_next = cl;
            phase_next     = (cl != '0) ? lzrle_pkg::PH_LIT_COPY : lzrle_pkg::PH_CTRL;
          end
        end
        lzrle_pkg::PH_FILL_EXT: begin
          if (cmd) begin
            step.taken     = 1'b1;
            copy_left_next = copy_left + ext;
            phase_next     = lzrle_pkg::PH_FILL_VAL;
          end
        end
        lzrle_pkg::PH_FILL_VAL: begin
          if (cmd) begin
            step.taken      = 1'b1;
            fill_value_next = b;
            cl              = clamp_run(copy_left, rem);
            copy_left_next  = cl;
            phase_next      = (cl != '0) ? lzrle_pkg::PH_FILL_OUT : lzrle_pkg::PH_CTRL;
          end
        end
        lzrle_pkg::PH_REF_LOW: begin
          if (cmd) begin
            step.taken    = 1'b1;
            distance_next = {distance[AW-1:8], b};
            phase_next    = lzrle_pkg::PH_REF_OUT;
          end
        end
        lzrle_pkg::PH_PAT_CNT: begin
          if (cmd) begin
            step.taken = 1'b1;
            // The pattern length is at most 65 here, so seven bits carry it.
            repeat_left_next = RW'(b) * RW'(copy_left[6:0]);
            phase_next       = lzrle_pkg::PH_PAT_LIT;
          end
        end
        lzrle_pkg::PH_LIT_COPY: begin
          if (cmd) begin
            step.taken     = 1'b1;
            step.emit      = 1'b1;
            step.lit_byte  = b;
            cd             = dec_sat(copy_left);
            copy_left_next = cd;
            if (cd == '0) begin
              phase_next = lzrle_pkg::PH_CTRL;
            end
          end
        end
        lzrle_pkg::PH_PAT_LIT: begin
          if (cmd) begin
            step.taken     = 1'b1;
            step.emit      = 1'b1;
            step.lit_byte  = b;
            cd             = dec_sat(copy_left);
            copy_left_next = cd;
            if (cd == '0) begin
              // Clamp against what is left after this byte.
              cl               = clamp_run(repeat_left, rem_m1);
              repeat_left_next = cl;
              phase_next       = (cl != '0) ? lzrle_pkg::PH_PAT_REP : lzrle_pkg::PH_CTRL;
            end
          end
        end
        lzrle_pkg::PH_FILL_OUT: begin
          step.emit      = 1'b1;
          step.lit_byte  = fill_value;
          cd             = dec_sat(copy_left);
          copy_left_next = cd;
          if (cd == '0) begin
            phase_next = lzrle_pkg::PH_CTRL;
          end
        end
        lzrle_pkg::PH_REF_OUT: begin
          step.emit      = 1'b1;
          step.lookup    = 1'b1;
          cd             = dec_sat(copy_left);
          copy_left_next = cd;
          if (cd == '0) begin
            phase_next = lzrle_pkg::PH_CTRL;
          end
        end
        lzrle_pkg::PH_PAT_REP: begin
          step.emit        = 1'b1;
          step.lookup      = 1'b1;
          cd               = dec_sat(repeat_left);
          repeat_left_next = cd;
          if (cd == '0) begin
            phase_next = lzrle_pkg::PH_CTRL;
          end
        end
        default: begin
          phase_next = lzrle_pkg::PH_CTRL;
          if (cmd && !out_done && read_count < input_size) begin
            step.taken = 1'b1;
            if (b[7] && b[6]) begin
              copy_left_next = RW'(b[4:0]) + RW'(2);
              phase_next     = b[5] ? lzrle_pkg::PH_FILL_EXT : lzrle_pkg::PH_FILL_VAL;
            end else if (b[7]) begin
              cl             = clamp_run(RW'(b[5:2]) + RW'(2), rem);
              copy_left_next = cl;
              distance_next  = {b[1:0], 8'h00};
              phase_next     = (cl != '0) ? lzrle_pkg::PH_REF_LOW : lzrle_pkg::PH_CTRL;
            end else if (b[6]) begin
              cl             = clamp_run(RW'(b[5:0]) + RW'(2), rem);
              copy_left_next = cl;
              distance_next  = (cl != '0) ? cl[AW-1:0] - AW'(1) : '0;
              phase_next     = (cl != '0) ? lzrle_pkg::PH_PAT_CNT : lzrle_pkg::PH_CTRL;
            end else if (b[5]) begin
              copy_left_next = RW'(b[4:0]) + RW'(1);
              phase_next     = lzrle_pkg::PH_LIT_EXT;
            end else begin
              cl             = clamp_run(RW'(b[4:0]) + RW'(1), rem);
              copy_left_next = cl;
              phase_next     = (cl != '0) ? lzrle_pkg::PH_LIT_COPY : lzrle_pkg::PH_CTRL;
            end
          end
        end
      endcase
    end

    if (step.taken && read_count != '1) begin
      read_count_next = read_count + SIZE_BITS'(1);
    end
    if (step.emit) begin
      written_count_next = written_count + SIZE_BITS'(1);
    end
    step.finished = (written_count_next >= output_size) ||
                    (phase_next == lzrle_pkg::PH_CTRL && read_count_next >= input_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
      read_count    <= '0;
      phase         <= lzrle_pkg::PH_CTRL;
      copy_left     <= '0;
      repeat_left   <= '0;
      distance      <= '0;
      fill_value    <= '0;
    end else if (accept) begin
      written_count <= written_count_next;
      read_count    <= read_count_next;
      phase         <= phase_next;
      copy_left     <= copy_left_next;
      repeat_left   <= repeat_left_next;
      distance      <= distance_next;
      fill_value    <= fill_value_next;
    end
  end

endmodule

// ----- sv/lzrle_emit.sv -----
// Emit stage: history window, look-back read with forwarding, and the result register.
module lzrle_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lzrle_pkg::step_t    step,
  output logic                can_accept,
  output logic                res_valid,
  input  logic                res_ready,
  output lzrle_pkg::out_item_t res_data
);

  localparam int AW = lzrle_pkg::HIST_AW;

  lzrle_pkg::step_t b;
  logic             b_vld;
  logic             b_fwd;
  logic [7:0]       fwd_byte;
  logic             b_adv;
  logic [7:0]       resolved;
  logic [7:0]       rdata;
  logic             clearing;
  logic [AW-1:0]    clr_addr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  // A look-back at distance one reads the byte that the previous step writes
  // in the same cycle, so that byte is taken from the forwarding register.
  assign resolved   = b.lookup ? (b_fwd ? fwd_byte : rdata) : b.lit_byte;
  assign b_adv      = b_vld && (!res_valid || res_ready);
  assign can_accept = !clearing && (!b_vld || b_adv);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = b_adv && b.emit;
      ram_waddr = b.wr_addr;
      ram_wdata = resolved;
    end
  end

  lzrle_ram #(
    .WIDTH (8),
    .DEPTH (lzrle_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (step.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (accept) begin
      b_vld <= 1'b1;
    end else if (b_adv) begin
      b_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b     <= step;
      b_fwd <= b_vld && b.emit && (step.rd_addr == b.wr_addr);
    end
    if (b_adv) begin
      fwd_byte          <= resolved;
      res_data.byte_taken <= b.taken;
      res_data.out_valid  <= b.emit;
      res_data.out_byte   <= b.emit ? resolved : 8'h00;
      res_data.finished   <= b.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LZ/RLE byte decompressor.
module tb;

  localparam logic [1:0] TOK_PAT  = 2'b01;
  localparam logic [1:0] TOK_REF  = 2'b10;
  localparam logic [1:0] TOK_FILL = 2'b11;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RUN_LIMIT_NS = 8_000_000;

  typedef struct packed {
    logic [lzrle_pkg::HIST_DEPTH-1:0][7:0] hist;
    logic [23:0]                           wr_cnt;
    logic [23:0]                           rd_cnt;
    logic [3:0]                            ph;
    logic [lzrle_pkg::RUN_W-1:0]           copy_left;
    logic [lzrle_pkg::RUN_W-1:0]           repeat_left;
    logic [lzrle_pkg::HIST_AW-1:0]         ref_dist;
    logic [7:0]                            fill;
  } dec_state_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  lzrle_pkg::in_item_t  in_data = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  lzrle_pkg::out_item_t res_data;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = lzrle_pkg::CFG_INPUT_SIZE;
  logic [23:0]          cfg_data = '0;

  // The decoder state is kept twice: one copy runs ahead while stimulus is built,
  // the other advances only on accepted input transfers and yields expectations.
  dec_state_t  plan_dec = '0;
  dec_state_t  acc_dec = '0;
  logic [23:0] cfg_in_size = '0;
  logic [23:0] cfg_out_size = '0;

  lzrle_pkg::in_item_t  byte_feed_q[$];
  lzrle_pkg::out_item_t step_res_q[$];
  logic [7:0]           stream_q[$];

  logic        in_taken = 1'b0;
  int unsigned bad_cnt = 0;
  int unsigned useful_cnt = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 53;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  lz_rle_byte_decompressor u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] clamp_run(logic [23:0] wr, logic [31:0] n);
    logic [31:0] room;
    room = cfg_out_size > wr ? 32'(cfg_out_size - wr) : 32'd0;
    return n < room ? n : room;
  endfunction

  function automatic logic [7:0] look_back(dec_state_t s);
    logic [lzrle_pkg::HIST_AW-1:0] idx;
    idx = s.wr_cnt[lzrle_pkg::HIST_AW-1:0] - s.ref_dist - 1'b1;
    return s.hist[idx];
  endfunction

  function automatic void take_byte(inout dec_state_t s, inout lzrle_pkg::out_item_t r);
    r.byte_taken = 1'b1;
    if (s.rd_cnt != '1) s.rd_cnt = s.rd_cnt + 1'b1;
  endfunction

  function automatic void put_byte(inout dec_state_t s, inout lzrle_pkg::out_item_t r,
                                   input logic [7:0] b);
    s.hist[s.wr_cnt[lzrle_pkg::HIST_AW-1:0]] = b;
    s.wr_cnt = s.wr_cnt + 1'b1;
    r.out_valid = 1'b1;
    r.out_byte = b;
  endfunction

  function automatic void run_down(inout dec_state_t s, input bit rep);
    if (rep) begin
      if (s.repeat_left != 0) s.repeat_left = s.repeat_left - 1'b1;
      if (s.repeat_left == 0) s.ph = lzrle_pkg::PH_CTRL;
    end else begin
      if (s.copy_left != 0) s.copy_left = s.copy_left - 1'b1;
      if (s.copy_left == 0) s.ph = lzrle_pkg::PH_CTRL;
    end
  endfunction

  function automatic lzrle_pkg::out_item_t decode_step(inout dec_state_t s,
                                                       input lzrle_pkg::in_item_t it);
    lzrle_pkg::out_item_t r;
    logic [7:0]           b;
    r = '0;
    b = it.src_byte;
    // A token still open when the output size is reached is dropped.
    if (s.ph != lzrle_pkg::PH_CTRL && s.wr_cnt >= cfg_out_size) begin
      s.ph = lzrle_pkg::PH_CTRL;
    end else begin
      case (s.ph)
        lzrle_pkg::PH_LIT_EXT: if (it.command) begin
          take_byte(s, r);
          s.copy_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt,
                                                    32'(s.copy_left) + (32'(b) << 5)));
          s.ph = s.copy_left != 0 ? lzrle_pkg::PH_LIT_COPY : lzrle_pkg::PH_CTRL;
        end
        lzrle_pkg::PH_FILL_EXT: if (it.command) begin
          take_byte(s, r);
          s.copy_left = lzrle_pkg::RUN_W'(32'(s.copy_left) + (32'(b) << 5));
          s.ph = lzrle_pkg::PH_FILL_VAL;
        end
        lzrle_pkg::PH_FILL_VAL: if (it.command) begin
          take_byte(s, r);
          s.fill = b;
          s.copy_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt, 32'(s.copy_left)));
          s.ph = s.copy_left != 0 ? lzrle_pkg::PH_FILL_OUT : lzrle_pkg::PH_CTRL;
        end
        lzrle_pkg::PH_REF_LOW: if (it.command) begin
          take_byte(s, r);
          s.ref_dist = {s.ref_dist[lzrle_pkg::HIST_AW-1:8], b};
          s.ph = lzrle_pkg::PH_REF_OUT;
        end
        lzrle_pkg::PH_PAT_CNT: if (it.command) begin
          take_byte(s, r);
          s.repeat_left = lzrle_pkg::RUN_W'(32'(b) * 32'(s.copy_left));
          s.ph = lzrle_pkg::PH_PAT_LIT;
        end
        lzrle_pkg::PH_LIT_COPY: if (it.command) begin
          take_byte(s, r);
          put_byte(s, r, b);
          run_down(s, 1'b0);
        end
        lzrle_pkg::PH_PAT_LIT: if (it.command) begin
          take_byte(s, r);
          put_byte(s, r, b);
          run_down(s, 1'b0);
          if (s.ph == lzrle_pkg::PH_CTRL) begin
            s.repeat_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt, 32'(s.repeat_left)));
            if (s.repeat_left != 0) s.ph = lzrle_pkg::PH_PAT_REP;
          end
        end
        lzrle_pkg::PH_FILL_OUT: begin
          put_byte(s, r, s.fill);
          run_down(s, 1'b0);
        end
        lzrle_pkg::PH_REF_OUT: begin
          put_byte(s, r, look_back(s));
          run_down(s, 1'b0);
        end
        lzrle_pkg::PH_PAT_REP: begin
          put_byte(s, r, look_back(s));
          run_down(s, 1'b1);
        end
        default: begin
          s.ph = lzrle_pkg::PH_CTRL;
          if (it.command && s.wr_cnt < cfg_out_size && s.rd_cnt < cfg_in_size) begin
            take_byte(s, r);
            case (b[7:6])
              TOK_FILL: begin
                s.copy_left = lzrle_pkg::RUN_W'(b[4:0] + 2);
                s.ph = b[5] ? lzrle_pkg::PH_FILL_EXT : lzrle_pkg::PH_FILL_VAL;
              end
              TOK_REF: begin
                s.copy_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt, 32'(b[5:2]) + 2));
                s.ref_dist = {b[1:0], 8'h00};
                s.ph = s.copy_left != 0 ? lzrle_pkg::PH_REF_LOW : lzrle_pkg::PH_CTRL;
              end
              TOK_PAT: begin
                s.copy_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt, 32'(b[5:0]) + 2));
                s.ref_dist = s.copy_left != 0 ?
                             lzrle_pkg::HIST_AW'(s.copy_left - 1'b1) : '0;
                s.ph = s.copy_left != 0 ? lzrle_pkg::PH_PAT_CNT : lzrle_pkg::PH_CTRL;
              end
              default: begin
                s.copy_left = lzrle_pkg::RUN_W'(b[4:0] + 1);
                if (b[5]) begin
                  s.ph = lzrle_pkg::PH_LIT_EXT;
                end else begin
                  s.copy_left = lzrle_pkg::RUN_W'(clamp_run(s.wr_cnt, 32'(s.copy_left)));
                  s.ph = s.copy_left != 0 ? lzrle_pkg::PH_LIT_COPY : lzrle_pkg::PH_CTRL;
                end
              end
            endcase
          end
        end
      endcase
    end
    r.finished = (s.wr_cnt >= cfg_out_size) ||
                 (s.ph == lzrle_pkg::PH_CTRL && s.rd_cnt >= cfg_in_size);
    return r;
  endfunction

  // Queue one item for the driver and advance the look-ahead decoder with it.
  function automatic lzrle_pkg::out_item_t offer(lzrle_pkg::in_item_t it);
    lzrle_pkg::out_item_t r;
    r = decode_step(plan_dec, it);
    byte_feed_q.push_back(it);
    if (r.byte_taken || r.out_valid) useful_cnt++;
    return r;
  endfunction

  task automatic add_token(input bit big_ok);
    logic [7:0]  ctl;
    logic [7:0]  ext;
    int unsigned n;
    ctl = 8'($urandom);
    ext = (big_ok && $urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
    end else begin
      case (ctl[7:6])
        TOK_FILL: begin
          stream_q.push_back(ctl);
          if (ctl[5]) stream_q.push_back(ext);
          stream_q.push_back(8'($urandom));
        end
        TOK_REF: begin
          stream_q.push_back(ctl);
          stream_q.push_back(8'($urandom));
        end
        TOK_PAT: begin
          if ($urandom_range(3) != 0) ctl[5:0] = 6'($urandom_range(6));
          stream_q.push_back(ctl);
          stream_q.push_back((big_ok && $urandom_range(7) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(4)));
          repeat (ctl[5:0] + 2) stream_q.push_back(8'($urandom));
        end
        default: begin
          if ($urandom_range(2) != 0) ctl[4:0] = 5'($urandom_range(7));
          stream_q.push_back(ctl);
          n = ctl[4:0] + 1;
          if (ctl[5]) begin
            stream_q.push_back(ext);
            n += 32'(ext) << 5;
          end
          // Long runs only get a short tail; the output size cuts them off anyway.
          repeat (n < 60 ? n : 60) stream_q.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  // Offers the stream byte by byte, repeating a byte until the decoder takes it, then pads out any open output run.
  task automatic feed_stream(input int unsigned tick_pct);
    int unsigned          ptr;
    lzrle_pkg::in_item_t  it;
    lzrle_pkg::out_item_t r;
    ptr = 0;
    while (ptr < stream_q.size() && !(plan_dec.ph == lzrle_pkg::PH_CTRL &&
           (plan_dec.wr_cnt >= cfg_out_size || plan_dec.rd_cnt >= cfg_in_size))) begin
      it.command = $urandom_range(99) >= tick_pct;
      it.src_byte = it.command ? stream_q[ptr] : 8'($urandom);
      r = offer(it);
      if (r.byte_taken) ptr++;
    end
    while (plan_dec.ph inside {lzrle_pkg::PH_FILL_OUT, lzrle_pkg::PH_REF_OUT,
                               lzrle_pkg::PH_PAT_REP})
      void'(offer(lzrle_pkg::in_item_t'(9'($urandom))));
    stream_q.delete();
  endtask

  task automatic write_sizes(input logic [23:0] isz, input logic [23:0] osz);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lzrle_pkg::CFG_INPUT_SIZE;
    cfg_data <= isz;
    @(negedge clk);
    cfg_index <= lzrle_pkg::CFG_OUTPUT_SIZE;
    cfg_data <= osz;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_in_size = isz;
    cfg_out_size = osz;
  endtask

  task automatic wait_idle();
    while (byte_feed_q.size() != 0 || in_valid || step_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: a new item goes out once the previous one has been transferred.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= byte_feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Monitor: checks result transfers and predicts from input transfers.
  always @(posedge clk) begin
    lzrle_pkg::out_item_t want;
    in_taken = !rst && in_valid && in_ready;
    if (!rst && res_valid && res_ready) begin
      if (step_res_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("tb: result at %0t with nothing outstanding", $time);
      end else begin
        want = step_res_q.pop_front();
        if (res_data.byte_taken !== want.byte_taken || res_data.out_valid !== want.out_valid ||
            res_data.out_byte !== want.out_byte || res_data.finished !== want.finished) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("tb: mismatch at %0t: want %0b/%0b/%02h/%0b got %0b/%0b/%02h/%0b",
                     $time,
                     want.byte_taken, want.out_valid, want.out_byte, want.finished,
                     res_data.byte_taken, res_data.out_valid, res_data.out_byte,
                     res_data.finished);
        end
      end
    end
    if (in_taken) step_res_q.push_back(decode_step(acc_dec, in_data));
  end

  initial begin
    int unsigned ph_i;
    int unsigned len;
    int unsigned pick;
    logic [23:0] isz;
    logic [23:0] osz;
    bit          hold_phase;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Both sizes are zero out of reset, so an offered byte must be refused.
    void'(offer('{command: 1'b1, src_byte: 8'hFF}));
    void'(offer('{command: 1'b0, src_byte: 8'h00}));
    wait_idle();

    write_sizes(24'd1000, 24'd1000);
    // Reference into the cleared history, a literal run, a pattern, an extended fill,
    // then a literal run left open.
    stream_q = '{8'h80, 8'h00,
                 8'h01, 8'h00, 8'hFF,
                 8'h40, 8'h01, 8'h12, 8'h34,
                 8'hE0, 8'h00, 8'h3C,
                 8'h03, 8'h77};
    feed_stream(0);
    wait_idle();
    // Lowering the output size to what is already written drops the open token.
    write_sizes(cfg_in_size, plan_dec.wr_cnt);
    void'(offer('{command: 1'b1, src_byte: 8'h11}));
    void'(offer('{command: 1'b1, src_byte: 8'h11}));
    wait_idle();

    useful_cnt = 0;
    for (ph_i = 0; ph_i < 9 || useful_cnt < 750; ph_i++) begin
      if (ph_i == 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 28;
      end else if (ph_i == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      hold_phase = ph_i == 2 || ph_i == 7;
      repeat ($urandom_range(3, 10)) add_token(ph_i != 1);
      len = stream_q.size();
      if (ph_i == 1) begin
        isz = '1;
        osz = '1;
      end else if (ph_i == 4) begin
        isz = '0;
        osz = '0;
      end else begin
        isz = plan_dec.rd_cnt + 24'($urandom_range(3) == 0 ? $urandom_range(len) : len);
        pick = hold_phase ? 0 : $urandom_range(9);
        if (pick < 7) osz = plan_dec.wr_cnt + 24'($urandom_range(20, 150));
        else if (pick < 9) osz = plan_dec.wr_cnt + 24'($urandom_range(3));
        else osz = 24'($urandom_range(plan_dec.wr_cnt));
      end
      write_sizes(isz, osz);
      if (hold_phase) holds_asked++;
      feed_stream(15);
      repeat ($urandom_range(4)) void'(offer(lzrle_pkg::in_item_t'(9'($urandom))));
      wait_idle();
    end

    if (bad_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- lz_rle_byte_decompressor.f -----
sv/lzrle_pkg.sv
sv/lzrle_ram.sv
sv/lzrle_decode.sv
sv/lzrle_emit.sv
sv/lz_rle_byte_decompressor.sv
tb/tb.sv
